FILE: design/uifhg_pkg.sv
// Shared types, constants and helpers for the UDP/IPv4 frame header generator.
`default_nettype none

package uifhg_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 16;
  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int POS_W      = 6;
  localparam int SUM_W      = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_MAC    = 3'd0,
    REG_DST_MAC    = 3'd1,
    REG_ETH_ENABLE = 3'd2,
    REG_SRC_IP     = 3'd3,
    REG_DST_IP     = 3'd4,
    REG_UDP_SPORT  = 3'd5,
    REG_UDP_DPORT  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_BEGIN   = 1'b0,
    REQ_PAYLOAD = 1'b1
  } req_kind_t;

  typedef enum logic {
    CMD_HDR = 1'b0,
    CMD_PAY = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic              eth_enable;
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [PORT_W-1:0] udp_sport;
    logic [PORT_W-1:0] udp_dport;
  } cfg_t;

  // One queue entry: a header burst or a single payload byte.
  typedef struct packed {
    cmd_kind_t         kind;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  localparam logic [15:0]     ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0]     IP_VER_TOS     = 16'h4500;
  localparam logic [15:0]     IP_ID          = 16'h6a45;
  localparam logic [15:0]     IP_FRAG        = 16'h0000;
  localparam logic [15:0]     IP_TTL_PROTO   = 16'h8011;  // TTL 128, protocol 17
  localparam logic [LEN_W-1:0] IP_HDR_LEN    = 16'd20;
  localparam logic [LEN_W-1:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0]     CKS_MASK       = 16'hffff;

  localparam logic [SUM_W-1:0] IP_SUM_BASE =
      SUM_W'(IP_VER_TOS) + SUM_W'(IP_ID) + SUM_W'(IP_FRAG) + SUM_W'(IP_TTL_PROTO);

  // Byte positions in the full Ethernet + IPv4 + UDP header layout.
  localparam logic [POS_W-1:0] POS_ETH_FIRST = 6'd0;
  localparam logic [POS_W-1:0] POS_SMAC      = 6'd6;
  localparam logic [POS_W-1:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [POS_W-1:0] POS_IP_FIRST  = 6'd14;
  localparam logic [POS_W-1:0] POS_IP_TOT_HI = 6'd16;
  localparam logic [POS_W-1:0] POS_IP_TOT_LO = 6'd17;
  localparam logic [POS_W-1:0] POS_IP_ID_HI  = 6'd18;
  localparam logic [POS_W-1:0] POS_IP_ID_LO  = 6'd19;
  localparam logic [POS_W-1:0] POS_IP_TTL    = 6'd22;
  localparam logic [POS_W-1:0] POS_IP_PROTO  = 6'd23;
  localparam logic [POS_W-1:0] POS_IP_CKS_HI = 6'd24;
  localparam logic [POS_W-1:0] POS_IP_CKS_LO = 6'd25;
  localparam logic [POS_W-1:0] POS_IP_SRC    = 6'd26;
  localparam logic [POS_W-1:0] POS_IP_DST    = 6'd30;
  localparam logic [POS_W-1:0] POS_IP_LAST   = 6'd33;
  localparam logic [POS_W-1:0] POS_UDP_FIRST = 6'd34;
  localparam logic [POS_W-1:0] POS_UDP_DP_HI = 6'd36;
  localparam logic [POS_W-1:0] POS_UDP_DP_LO = 6'd37;
  localparam logic [POS_W-1:0] POS_UDP_LEN_HI = 6'd38;
  localparam logic [POS_W-1:0] POS_UDP_LEN_LO = 6'd39;
  localparam logic [POS_W-1:0] POS_UDP_LAST  = 6'd41;

  function automatic logic has_ip(input cfg_t c);
    return (c.src_ip != '0) && (c.dst_ip != '0);
  endfunction

  function automatic logic has_udp(input cfg_t c);
    return (c.udp_sport != '0) && (c.udp_dport != '0);
  endfunction

  // Byte i of a MAC, byte 0 being the most significant (first on the wire).
  function automatic logic [BYTE_W-1:0] mac_byte(input logic [MAC_W-1:0] mac,
                                                 input logic [2:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] ip_byte(input logic [IP_W-1:0] addr,
                                                input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = addr[31:24];
      2'd1:    b = addr[23:16];
      2'd2:    b = addr[15:8];
      default: b = addr[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: design/uifhg_ifs.sv
// Valid/ready channel interfaces for the request input and the frame byte output.
`default_nettype none

interface uifhg_in_if import uifhg_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [LEN_W-1:0]  payload_len;
  logic [BYTE_W-1:0] data_byte;

  modport source(output valid, req_type, payload_len, data_byte, input ready);
  modport sink(input valid, req_type, payload_len, data_byte, output ready);
endinterface

interface uifhg_out_if import uifhg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source(output valid, out_byte, last, input ready);
  modport sink(input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

FILE: design/uifhg_front.sv
// Front end: accepts requests, tracks the open packet and queues commands.
`default_nettype none

module uifhg_front import uifhg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  uifhg_in_if.sink   in_ch,
  input  wire cfg_t  cfg,
  input  wire logic  q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic             open_r, open_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             accept;
  logic             any_hdr;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign any_hdr     = cfg.eth_enable || has_ip(cfg) || has_udp(cfg);

  always_comb begin
    open_nxt = open_r;
    left_nxt = left_r;
    q_push   = 1'b0;
    q_cmd    = '{kind: CMD_HDR, last: 1'b0, len: in_ch.payload_len, data: in_ch.data_byte};
    if (accept) begin
      if (in_ch.req_type == REQ_BEGIN) begin
        // a begin abandons whatever packet was open
        open_nxt   = (in_ch.payload_len != '0);
        left_nxt   = in_ch.payload_len;
        q_push     = any_hdr;
        q_cmd.last = (in_ch.payload_len == '0);
      end else if (open_r && (left_r != '0)) begin
        q_push     = 1'b1;
        q_cmd.kind = CMD_PAY;
        q_cmd.last = (left_r == LEN_W'(1));
        left_nxt   = left_r - LEN_W'(1);
        open_nxt   = (left_r != LEN_W'(1));
      end else begin
        open_nxt = 1'b0;
        left_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= '0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/uifhg_cmd_fifo.sv
// Small command queue between the front end and the byte sequencer.
`default_nettype none

module uifhg_cmd_fifo import uifhg_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/uifhg_back.sv
// Back end: walks header byte positions, passes payload bytes, holds the output register.
`default_nettype none

module uifhg_back import uifhg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire cmd_t  head,
  input  wire logic  q_empty,
  output logic       q_pop,
  uifhg_out_if.source out_ch
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              hdr_act_r, hdr_act_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  tot_r, tot_nxt;
  logic [LEN_W-1:0]  ulen_r, ulen_nxt;
  logic [SUM_W-1:0]  ip_sum_r;
  logic [SUM_W-1:0]  csum_r;
  logic [16:0]       fold1;
  logic [15:0]       fold2;
  logic [15:0]       cks;
  logic              ip_on, udp_on;
  logic              load_ok;
  logic [POS_W-1:0]  pos_start, pos_end, pos_step;
  logic [POS_W-1:0]  rel;
  logic [BYTE_W-1:0] hdr_byte;

  assign ip_on   = has_ip(cfg);
  assign udp_on  = has_udp(cfg);
  assign load_ok = !out_valid_r || out_ch.ready;

  assign pos_start = cfg.eth_enable ? POS_ETH_FIRST : (ip_on ? POS_IP_FIRST : POS_UDP_FIRST);
  assign pos_end   = udp_on ? POS_UDP_LAST : (ip_on ? POS_IP_LAST : POS_ETYPE_LO);

  always_comb begin
    if (pos_r == POS_ETYPE_LO) begin
      pos_step = ip_on ? POS_IP_FIRST : POS_UDP_FIRST;
    end else begin
      pos_step = pos_r + POS_W'(1);
    end
  end

  // ones' complement fold of the IPv4 header sum
  assign fold1 = 17'(csum_r[15:0]) + 17'(csum_r[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign cks   = ~fold2 & CKS_MASK;

  always_comb begin
    rel = '0;
    unique case (pos_r) inside
      [POS_ETH_FIRST:POS_SMAC-6'd1]: begin
        rel      = pos_r - POS_ETH_FIRST;
        hdr_byte = mac_byte(cfg.dst_mac, rel[2:0]);
      end
      [POS_SMAC:POS_ETYPE_HI-6'd1]: begin
        rel      = pos_r - POS_SMAC;
        hdr_byte = mac_byte(cfg.src_mac, rel[2:0]);
      end
      POS_ETYPE_HI:   hdr_byte = ETHERTYPE_IPV4[15:8];
      POS_ETYPE_LO:   hdr_byte = ETHERTYPE_IPV4[7:0];
      POS_IP_FIRST:   hdr_byte = IP_VER_TOS[15:8];
      POS_IP_TOT_HI:  hdr_byte = tot_r[15:8];
      POS_IP_TOT_LO:  hdr_byte = tot_r[7:0];
      POS_IP_ID_HI:   hdr_byte = IP_ID[15:8];
      POS_IP_ID_LO:   hdr_byte = IP_ID[7:0];
      POS_IP_TTL:     hdr_byte = IP_TTL_PROTO[15:8];
      POS_IP_PROTO:   hdr_byte = IP_TTL_PROTO[7:0];
      POS_IP_CKS_HI:  hdr_byte = cks[15:8];
      POS_IP_CKS_LO:  hdr_byte = cks[7:0];
      [POS_IP_SRC:POS_IP_DST-6'd1]: begin
        rel      = pos_r - POS_IP_SRC;
        hdr_byte = ip_byte(cfg.src_ip, rel[1:0]);
      end
      [POS_IP_DST:POS_IP_LAST]: begin
        rel      = pos_r - POS_IP_DST;
        hdr_byte = ip_byte(cfg.dst_ip, rel[1:0]);
      end
      POS_UDP_FIRST:       hdr_byte = cfg.udp_sport[15:8];
      POS_UDP_FIRST + 6'd1: hdr_byte = cfg.udp_sport[7:0];
      POS_UDP_DP_HI:       hdr_byte = cfg.udp_dport[15:8];
      POS_UDP_DP_LO:       hdr_byte = cfg.udp_dport[7:0];
      POS_UDP_LEN_HI:      hdr_byte = ulen_r[15:8];
      POS_UDP_LEN_LO:      hdr_byte = ulen_r[7:0];
      default:             hdr_byte = '0;  // zero fields and UDP checksum
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    hdr_act_nxt  = hdr_act_r;
    pos_nxt      = pos_r;
    tot_nxt      = tot_r;
    ulen_nxt     = ulen_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (!q_empty) begin
      if (head.kind == CMD_PAY) begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = head.data;
          out_last_nxt  = head.last;
          q_pop         = 1'b1;
        end
      end else if (!hdr_act_r) begin
        // setup cycle: latch lengths, checksum settles well before its byte
        hdr_act_nxt = 1'b1;
        pos_nxt     = pos_start;
        tot_nxt     = IP_HDR_LEN + (udp_on ? UDP_HDR_LEN : '0) + head.len;
        ulen_nxt    = UDP_HDR_LEN + head.len;
      end else if (load_ok) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = hdr_byte;
        out_last_nxt  = (pos_r == pos_end) && head.last;
        if (pos_r == pos_end) begin
          q_pop       = 1'b1;
          hdr_act_nxt = 1'b0;
        end else begin
          pos_nxt = pos_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ip_sum_r   <= IP_SUM_BASE
                + SUM_W'(cfg.src_ip[31:16]) + SUM_W'(cfg.src_ip[15:0])
                + SUM_W'(cfg.dst_ip[31:16]) + SUM_W'(cfg.dst_ip[15:0]);
    csum_r     <= ip_sum_r + SUM_W'(tot_r);
    pos_r      <= pos_nxt;
    tot_r      <= tot_nxt;
    ulen_r     <= ulen_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hdr_act_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hdr_act_r   <= hdr_act_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

endmodule

`default_nettype wire

FILE: design/udp_ipv4_frame_header_generator_unit.sv
// Top level of the UDP/IPv4/Ethernet frame header generator.
`default_nettype none

// Turns a request stream into frame bytes. A begin request (req_type 0) carries
// the payload length and produces the enabled headers: Ethernet (14 bytes,
// eth_enable), IPv4 (20 bytes, both addresses nonzero) and UDP (8 bytes, both
// ports nonzero), with the IPv4 header checksum computed here. Payload requests
// (req_type 1) pass one byte each until the announced length is reached; the
// final frame byte carries last. A begin while a packet is open abandons it,
// and payload requests outside a packet are dropped without output.
// A begin has a setup step before its header bytes (up to 42) go out, paced by
// the back-end byte sequencer, which drives a single output register. The front
// end keeps accepting while the sequencer works, until the FIFO_DEPTH-entry
// command queue fills. No clearing pass after reset. Configuration (index:
// 0 src_mac, 1 dst_mac, 2 eth_enable, 3 src_ip, 4 dst_ip, 5 UDP source port,
// 6 UDP destination port) is written with cfg_we while the block is idle, which
// the user must ensure (not enforced); writes to index 7 are ignored.
module udp_ipv4_frame_header_generator_unit import uifhg_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  uifhg_in_if.sink                   in_ch,
  uifhg_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  // configuration registers; everything resets to zero except eth_enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{eth_enable: 1'b1, default: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_MAC:    cfg_r.src_mac    <= cfg_data[MAC_W-1:0];
        REG_DST_MAC:    cfg_r.dst_mac    <= cfg_data[MAC_W-1:0];
        REG_ETH_ENABLE: cfg_r.eth_enable <= cfg_data[0];
        REG_SRC_IP:     cfg_r.src_ip     <= cfg_data[IP_W-1:0];
        REG_DST_IP:     cfg_r.dst_ip     <= cfg_data[IP_W-1:0];
        REG_UDP_SPORT:  cfg_r.udp_sport  <= cfg_data[PORT_W-1:0];
        REG_UDP_DPORT:  cfg_r.udp_dport  <= cfg_data[PORT_W-1:0];
        default:        ;  // unmapped index
      endcase
    end
  end

  // front: classify requests, track packet length
  uifhg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  // decouples request acceptance from header byte emission
  uifhg_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back: header sequencer, payload pass-through, output register
  uifhg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: design/uifhg_checker.sv
// Port-level checks for the frame header generator, bound to its top level.
`default_nettype none

module uifhg_checker import uifhg_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_req_type,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("out payload changed while stalled");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a payload request right after reset has no open packet and yields nothing
  a_drop_outside: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && in_valid && in_ready && (in_req_type == REQ_PAYLOAD)
      |=> !out_valid)
    else $error("byte emitted outside a packet");

  // the queue is empty after reset, so requests are taken at once
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind udp_ipv4_frame_header_generator_unit uifhg_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .out_last    (out_ch.last)
);

`default_nettype wire

FILE: verif/tb_udp_ipv4_frame_header_generator_unit.sv
// Self-checking testbench for the UDP/IPv4/Ethernet frame header generator.
`default_nettype none

module tb_udp_ipv4_frame_header_generator_unit;
  import uifhg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index 7 is not a register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // No-accept cycles before the run is called hung. The longest legal quiet
  // stretch is the pause before a register change.
  localparam int STALL_LIMIT  = 4000;
  // Quiet cycles after the last expected byte, so a stray extra byte shows
  // up before the registers change.
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEMS_PER_SETTING = 12;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_byte_t;

  // Tracks the block's packet state and register copy, and holds the frame
  // bytes that accepted requests are owed.
  class frame_tracker;
    cfg_t             cfg;
    bit               packet_open;
    logic [LEN_W-1:0] bytes_left;
    frame_byte_t      pending_bytes[$];
    int               mismatches;
    int               bytes_checked;
    int               requests;

    function new();
      cfg = '0;
      cfg.eth_enable = 1'b1;
      packet_open = 1'b0;
      bytes_left = '0;
      mismatches = 0;
      bytes_checked = 0;
      requests = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SRC_MAC:    cfg.src_mac = v[MAC_W-1:0];
        REG_DST_MAC:    cfg.dst_mac = v[MAC_W-1:0];
        REG_ETH_ENABLE: cfg.eth_enable = v[0];
        REG_SRC_IP:     cfg.src_ip = v[IP_W-1:0];
        REG_DST_IP:     cfg.dst_ip = v[IP_W-1:0];
        REG_UDP_SPORT:  cfg.udp_sport = v[PORT_W-1:0];
        REG_UDP_DPORT:  cfg.udp_dport = v[PORT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void push_byte(logic [BYTE_W-1:0] b, logic last = 1'b0);
      frame_byte_t e;
      e.data = b;
      e.last = last;
      pending_bytes.push_back(e);
    endfunction

    function void push_word(logic [15:0] w);
      push_byte(w[15:8]);
      push_byte(w[7:0]);
    endfunction

    function void take_request(req_kind_t kind, logic [LEN_W-1:0] len,
                               logic [BYTE_W-1:0] data);
      logic        ip_on;
      logic        udp_on;
      logic [15:0] tot_len;
      logic [15:0] cks;
      logic [31:0] sum;
      int          start_size;
      frame_byte_t e;
      requests++;
      start_size = pending_bytes.size();
      if (kind == REQ_BEGIN) begin
        ip_on  = (cfg.src_ip != '0) && (cfg.dst_ip != '0);
        udp_on = (cfg.udp_sport != '0) && (cfg.udp_dport != '0);
        if (cfg.eth_enable) begin
          for (int i = 5; i >= 0; i--) push_byte(cfg.dst_mac[8*i +: 8]);
          for (int i = 5; i >= 0; i--) push_byte(cfg.src_mac[8*i +: 8]);
          // type is IPv4 even when the IP layer is off
          push_word(ETHERTYPE_IPV4);
        end
        if (ip_on) begin
          tot_len = IP_HDR_LEN + len + (udp_on ? UDP_HDR_LEN : 16'd0);  // wraps
          sum = 32'(IP_VER_TOS) + 32'(tot_len) + 32'(IP_ID) + 32'(IP_FRAG)
              + 32'(IP_TTL_PROTO)
              + 32'(cfg.src_ip[31:16]) + 32'(cfg.src_ip[15:0])
              + 32'(cfg.dst_ip[31:16]) + 32'(cfg.dst_ip[15:0]);
          sum = (sum >> 16) + (sum & 32'hffff);
          sum = sum + (sum >> 16);
          cks = ~sum[15:0];
          push_word(IP_VER_TOS);
          push_word(tot_len);
          push_word(IP_ID);
          push_word(IP_FRAG);
          push_word(IP_TTL_PROTO);
          push_word(cks);
          push_word(cfg.src_ip[31:16]);
          push_word(cfg.src_ip[15:0]);
          push_word(cfg.dst_ip[31:16]);
          push_word(cfg.dst_ip[15:0]);
        end
        if (udp_on) begin
          push_word(cfg.udp_sport);
          push_word(cfg.udp_dport);
          push_word(UDP_HDR_LEN + len);
          push_word(16'h0000);
        end
        if (len == '0) begin
          // empty payload: frame ends on the last header byte, if any
          packet_open = 1'b0;
          bytes_left = '0;
          if (pending_bytes.size() > start_size) begin
            e = pending_bytes.pop_back();
            e.last = 1'b1;
            pending_bytes.push_back(e);
          end
        end else begin
          // an open packet, if any, is simply dropped here
          packet_open = 1'b1;
          bytes_left = len;
        end
      end else if (!packet_open || bytes_left == '0) begin
        packet_open = 1'b0;
        bytes_left = '0;
      end else begin
        bytes_left = bytes_left - 1'b1;
        push_byte(data, bytes_left == '0);
        if (bytes_left == '0) packet_open = 1'b0;
      end
    endfunction

    function void compare_byte(logic [BYTE_W-1:0] data, logic last);
      frame_byte_t exp_b;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected byte %02h last %0b", $realtime, data, last);
      end else begin
        exp_b = pending_bytes.pop_front();
        if (exp_b.data !== data || exp_b.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                     $realtime, exp_b.data, exp_b.last, data, last);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  uifhg_in_if  in_ch();
  uifhg_out_if out_ch();

  udp_ipv4_frame_header_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: ready rolls each cycle against the current idle percentage.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitors: values read at the edge are the ones the block sampled there.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.take_request(req_kind_t'(in_ch.req_type), in_ch.payload_len,
                           in_ch.data_byte);
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.compare_byte(out_ch.out_byte, out_ch.last);
  end

  // Watchdog: ends a run in which nothing moves for too long.
  initial begin : watchdog
    int quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request or byte moved for %0d cycles", $realtime, STALL_LIMIT);
    $display("FAIL udp_ipv4_frame_header_generator_unit");
    $finish;
  end

  // One request; returns at the edge where it was taken. Valid stays high so
  // back-to-back requests keep the channel busy.
  task automatic send_req(req_kind_t kind, logic [LEN_W-1:0] len,
                          logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.payload_len <= len;
    in_ch.data_byte   <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every owed byte, then hold a quiet stretch.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  task automatic apply_cfg(cfg_t c, bit poke_unused);
    settle();
    write_reg(REG_SRC_MAC, CFG_DATA_W'(c.src_mac));
    write_reg(REG_DST_MAC, CFG_DATA_W'(c.dst_mac));
    write_reg(REG_ETH_ENABLE, CFG_DATA_W'(c.eth_enable));
    write_reg(REG_SRC_IP, CFG_DATA_W'(c.src_ip));
    write_reg(REG_DST_IP, CFG_DATA_W'(c.dst_ip));
    write_reg(REG_UDP_SPORT, CFG_DATA_W'(c.udp_sport));
    write_reg(REG_UDP_DPORT, CFG_DATA_W'(c.udp_dport));
    if (poke_unused)
      write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // 0 and all-ones show up often; zero also turns a layer off.
  function automatic logic [63:0] pick_value(int width);
    logic [63:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return v & ((64'd1 << width) - 1);
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.src_mac    = MAC_W'(pick_value(MAC_W));
    c.dst_mac    = MAC_W'(pick_value(MAC_W));
    c.eth_enable = ($urandom_range(3) != 0);
    c.src_ip     = IP_W'(pick_value(IP_W));
    c.dst_ip     = IP_W'(pick_value(IP_W));
    c.udp_sport  = PORT_W'(pick_value(PORT_W));
    c.udp_dport  = PORT_W'(pick_value(PORT_W));
    return c;
  endfunction

  // Mostly whole packets with random bytes; some cut short (a later begin
  // abandons them), a few huge lengths, and stray payload bytes as noise.
  task automatic run_packets(int budget);
    int               sent;
    int               nbytes;
    logic [LEN_W-1:0] len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 8) begin
        send_req(REQ_PAYLOAD, LEN_W'($urandom), BYTE_W'($urandom));
      end else begin
        if ($urandom_range(9) == 0) len = LEN_W'($urandom);
        else len = LEN_W'($urandom_range(6));
        send_req(REQ_BEGIN, len, BYTE_W'($urandom));
        sent++;
        if (len > 8) nbytes = $urandom_range(1, 4);
        else if ($urandom_range(9) == 0) nbytes = $urandom_range(int'(len));
        else nbytes = len;
        repeat (nbytes) begin
          send_req(REQ_PAYLOAD, LEN_W'($urandom), BYTE_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin : main
    cfg_t c;
    tracker = new();
    settings_used = 0;
    send_idle_pct = 16;
    recv_idle_pct = 83;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_SRC_MAC;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_BEGIN;
    in_ch.payload_len <= '0;
    in_ch.data_byte   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: Ethernet only with zero MACs, type still IPv4.
    send_req(REQ_PAYLOAD, '0, 8'h5a);         // no packet open: dropped
    send_req(REQ_BEGIN, 16'd0, 8'h00);        // header only, last on its end
    send_req(REQ_BEGIN, 16'd1, 8'h00);
    send_req(REQ_PAYLOAD, '1, 8'h00);

    // All three layers, extreme addresses and ports.
    c.src_mac = 48'hffff_ffff_ffff;
    c.dst_mac = 48'h0123_4567_89ab;
    c.eth_enable = 1'b1;
    c.src_ip = 32'hffff_ffff;
    c.dst_ip = 32'h0a00_0001;
    c.udp_sport = 16'hffff;
    c.udp_dport = 16'h0001;
    apply_cfg(c, 1'b0);
    send_req(REQ_BEGIN, 16'd3, 8'h00);
    send_req(REQ_PAYLOAD, '0, 8'hff);
    send_req(REQ_PAYLOAD, '0, 8'h00);
    send_req(REQ_PAYLOAD, '0, 8'ha5);
    send_req(REQ_PAYLOAD, '0, 8'h3c);         // after the end: dropped
    send_req(REQ_BEGIN, 16'hffff, 8'h00);     // both lengths wrap
    send_req(REQ_PAYLOAD, '0, 8'h81);
    send_req(REQ_BEGIN, 16'd2, 8'h00);        // abandons the open packet
    send_req(REQ_PAYLOAD, '0, 8'h7e);
    send_req(REQ_PAYLOAD, '0, 8'hc3);
    send_req(REQ_BEGIN, 16'd65507, 8'h00);
    send_req(REQ_PAYLOAD, '0, 8'h11);
    send_req(REQ_BEGIN, 16'd0, 8'h00);        // abandon with an empty packet

    // IP only; the unused index gets a write too.
    c.eth_enable = 1'b0;
    c.src_ip = 32'hc0a8_0001;
    c.dst_ip = 32'hffff_ffff;
    c.udp_sport = 16'h0000;
    c.udp_dport = 16'h1234;
    apply_cfg(c, 1'b1);
    send_req(REQ_BEGIN, 16'd0, 8'h00);
    send_req(REQ_BEGIN, 16'd1, 8'h00);
    send_req(REQ_PAYLOAD, '0, 8'h96);

    // UDP only.
    c.src_ip = 32'h0000_0000;
    c.udp_sport = 16'h8000;
    apply_cfg(c, 1'b0);
    send_req(REQ_BEGIN, 16'd0, 8'h00);

    // Nothing enabled: an empty begin emits nothing, payload still passes.
    c.udp_dport = 16'h0000;
    apply_cfg(c, 1'b0);
    send_req(REQ_BEGIN, 16'd0, 8'h00);
    send_req(REQ_BEGIN, 16'd2, 8'h00);
    send_req(REQ_PAYLOAD, '0, 8'h01);
    send_req(REQ_PAYLOAD, '0, 8'h80);

    // Random traffic over three idle schedules, two settings each.
    for (int sched = 0; sched < 3; sched++) begin
      case (sched)
        0: begin send_idle_pct = 16; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 2; k++) begin
        apply_cfg(rand_cfg(), ($urandom_range(3) == 0));
        run_packets(ITEMS_PER_SETTING);
      end
    end

    settle();

    $display("Checked %0d frame bytes from %0d requests", tracker.bytes_checked,
             tracker.requests);
    $display("Covered %0d register settings under three idle schedules", settings_used);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS udp_ipv4_frame_header_generator_unit");
    end else begin
      $display("%0d mismatches, %0d bytes still owed", tracker.mismatches,
               tracker.pending());
      $display("FAIL udp_ipv4_frame_header_generator_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
